// ----- rtl/dtmf_pkg.sv -----
package dtmf_pkg;

   // Input field codes.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // Fixed-point constants for the quarter-wave sine series.
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   // Row and column frequencies in hertz.
   localparam logic [9:0] ROW_FREQ [4] = '{10'd697, 10'd770, 10'd852, 10'd941};
   localparam logic [10:0] COL_FREQ [4] = '{11'd1209, 11'd1477, 11'd1336, 11'd1336};

   // Routing flags of one control transaction.
   typedef struct packed {
      logic open_loop;
      logic progress;
      logic handset;
      logic line;
      logic speaker;
   } dtmf_route_type;

   // Decoded control state handed to the result register.
   typedef struct packed {
      logic           tone_active;
      logic [7:0]     tone_level;
      logic [9:0]     low_freq_hz;
      logic [10:0]    high_freq_hz;
      dtmf_route_type route;
      logic           digit_start;
   } dtmf_status_type;

   // Per-cycle control of one oscillator.
   typedef struct packed {
      logic tick;
      logic sound_on;
   } dtmf_osc_ctrl_type;

   // Q15 sine of (pi/2 * k / 2**quarter_bits), from a Q30 Taylor series.
   // Evaluated at elaboration only.
   function automatic logic [14:0] quarter_sine(input int unsigned k,
                                                input int unsigned quarter_bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      x    = (HALF_PI_Q30 * 64'(k)) >> quarter_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      r = ($unsigned(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[14:0];
   endfunction

endpackage

// ----- rtl/dtmf_ctrl.sv -----
module dtmf_ctrl #(
   parameter int PHASE_BITS = 32,
   parameter int SAMPLE_HZ  = 44100
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      write,
   input  logic [7:0]                tone_code,
   input  dtmf_pkg::dtmf_route_type  route,
   output dtmf_pkg::dtmf_status_type status,
   output logic                      sound_on,
   output logic [PHASE_BITS-1:0]     step_low,
   output logic [PHASE_BITS-1:0]     step_high
);
   import dtmf_pkg::*;

   // Phase increments, round(f * 2**PHASE_BITS / SAMPLE_HZ).
   localparam logic [63:0] ROW_STEP [4] = '{
      ((64'(ROW_FREQ[0]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ),
      ((64'(ROW_FREQ[1]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ),
      ((64'(ROW_FREQ[2]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ),
      ((64'(ROW_FREQ[3]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ)
   };
   localparam logic [63:0] COL_STEP [4] = '{
      ((64'(COL_FREQ[0]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ),
      ((64'(COL_FREQ[1]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ),
      ((64'(COL_FREQ[2]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ),
      ((64'(COL_FREQ[3]) << PHASE_BITS) + 64'(SAMPLE_HZ / 2)) / 64'(SAMPLE_HZ)
   };

   logic [7:0]     tone_ff;
   logic [7:0]     tone_in;
   dtmf_route_type route_ff;
   dtmf_route_type route_in;
   logic           sound_on_ff;
   logic           sound_on_in;
   logic           prev_line;
   logic [63:0]    row_step_full;
   logic [63:0]    col_step_full;

   // Next control state: a write replaces the tone byte and the flags.
   always_comb begin
      tone_in     = write ? tone_code : tone_ff;
      route_in    = write ? route : route_ff;
      sound_on_in = write ? ((tone_code != 8'd0) && route.speaker) : sound_on_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tone_ff     <= '0;
         route_ff    <= '0;
         sound_on_ff <= 1'b0;
      end else begin
         tone_ff     <= tone_in;
         route_ff    <= route_in;
         sound_on_ff <= sound_on_in;
      end
   end

   // A digit starts when the write makes an active tone to the line appear.
   assign prev_line = (tone_ff != 8'd0) && route_ff.line;

   // Status reflects the state as it stands after this transaction.
   always_comb begin
      status.tone_active  = tone_in != 8'd0;
      status.tone_level   = tone_in & 8'hF0;
      status.low_freq_hz  = ROW_FREQ[tone_in[1:0]];
      status.high_freq_hz = COL_FREQ[tone_in[3:2]];
      status.route        = route_in;
      status.digit_start  = write && (tone_code != 8'd0) && route.line && !prev_line;
   end

   // Steps follow the stored tone; they matter only while the sound is on.
   assign row_step_full = ROW_STEP[tone_ff[1:0]];
   assign col_step_full = COL_STEP[tone_ff[3:2]];
   assign step_low      = row_step_full[PHASE_BITS-1:0];
   assign step_high     = col_step_full[PHASE_BITS-1:0];
   assign sound_on      = sound_on_ff;

   // The sound can only be on for a nonzero tone routed to the speaker.
   a_sound_needs_tone: assert property (@(posedge clock) disable iff (reset)
      sound_on_ff |-> (tone_ff != 8'd0) && route_ff.speaker)
      else $error("sound on without an active speaker tone");

endmodule

// ----- rtl/dtmf_osc.sv -----
module dtmf_osc #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_INDEX_BITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dtmf_pkg::dtmf_osc_ctrl_type ctrl,
   input  logic [PHASE_BITS-1:0]       step,
   input  logic [13:0]                 amplitude,
   output logic signed [15:0]          tone
);
   import dtmf_pkg::*;

   localparam int QUARTER_BITS = SINE_INDEX_BITS - 2;
   localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
   localparam logic [QUARTER_BITS:0] QUARTER_K = (QUARTER_BITS + 1)'(QUARTER_LEN);

   logic [PHASE_BITS-1:0]      phase_ff;
   logic [PHASE_BITS-1:0]      phase_in;
   logic [14:0]                quarter_rom [QUARTER_LEN+1];
   logic [SINE_INDEX_BITS-1:0] index;
   logic [1:0]                 quad;
   logic [QUARTER_BITS-1:0]    offset;
   logic [QUARTER_BITS:0]      rom_addr;
   logic [14:0]                magnitude;
   logic signed [15:0]         sine;
   logic signed [30:0]         product;
   logic signed [30:0]         adjusted;

   // Quarter-wave sine table, values 0 through a full quarter.
   for (genvar gk = 0; gk <= QUARTER_LEN; gk++) begin : g_rom
      localparam logic [14:0] QV = quarter_sine(gk, QUARTER_BITS);
      assign quarter_rom[gk] = QV;
   end

   // Phase accumulator: advance on a tick while sounding, clear on a tick while silent, else hold.
   always_comb begin
      phase_in = phase_ff;
      if (ctrl.tick) begin
         phase_in = ctrl.sound_on ? phase_ff + step : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // Fold the table index into the first quarter and restore the sign.
   always_comb begin
      index     = phase_ff[PHASE_BITS-1 -: SINE_INDEX_BITS];
      quad      = index[SINE_INDEX_BITS-1 -: 2];
      offset    = index[QUARTER_BITS-1:0];
      rom_addr  = quad[0] ? QUARTER_K - {1'b0, offset} : {1'b0, offset};
      magnitude = quarter_rom[rom_addr];
      sine      = quad[1] ? -$signed({1'b0, magnitude}) : $signed({1'b0, magnitude});
   end

   // Scale by the amplitude and divide by 32768, truncating toward zero.
   always_comb begin
      product  = $signed({1'b0, amplitude}) * sine;
      adjusted = product[30] ? product + 31'sd32767 : product;
      tone     = $signed(adjusted[30:15]);
   end

   // A tick while silent leaves the phase at zero.
   a_phase_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.tick && !ctrl.sound_on |=> phase_ff == '0)
      else $error("phase not cleared by a silent tick");

endmodule

// ----- rtl/dtmf_dialer_tone_generator_top.sv -----
// An accepted transaction passes through the input register and then the result register,
// where a result stall can hold it. Throughput: one transaction per cycle unless stalled;
// the two registers let a new transaction in while a result waits to be taken.
// The per-item path is one quarter-wave sine lookup and one 15x16 multiply per tone.
// Reset (synchronous, active high) clears both valid flags, the stored tone and flags,
// both phases and the amplitude; the sine table is constant and needs no clearing pass.
module dtmf_dialer_tone_generator_top #(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_INDEX_BITS = 10,
   parameter int SAMPLE_HZ       = 44100
) (
   input  logic               clock,
   input  logic               reset,
   // Configuration write channel.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [13:0]        csr_tone_amplitude,
   // Input channel.
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [7:0]         req_tone_code,
   input  logic               req_speaker_on,
   input  logic               req_line_on,
   input  logic               req_handset_on,
   input  logic               req_progress_on,
   input  logic               req_open_loop,
   // Result channel.
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_tone_active,
   output logic [7:0]         rsp_tone_level,
   output logic [9:0]         rsp_low_freq_hz,
   output logic [10:0]        rsp_high_freq_hz,
   output logic               rsp_route_speaker,
   output logic               rsp_route_line,
   output logic               rsp_route_handset,
   output logic               rsp_route_progress,
   output logic               rsp_route_open,
   output logic               rsp_digit_start
);
   import dtmf_pkg::*;

   logic [13:0]           amp_ff;
   logic [13:0]           amp_in;
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic                  in_func_ff;
   logic [7:0]            in_tone_ff;
   dtmf_route_type        in_route_ff;
   logic                  req_accept;
   logic                  advance;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic signed [15:0]    rsp_sample_ff;
   logic signed [15:0]    rsp_sample_in;
   dtmf_status_type       rsp_status_ff;
   dtmf_status_type       status;
   logic                  sound_on;
   logic [PHASE_BITS-1:0] step_low;
   logic [PHASE_BITS-1:0] step_high;
   dtmf_osc_ctrl_type     osc_ctrl;
   logic signed [15:0]    tone_low;
   logic signed [15:0]    tone_high;

   // Amplitude register; writes are always taken.
   assign csr_ready    = 1'b1;
   assign amp_in       = (csr_valid && csr_ready) ? csr_tone_amplitude : amp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= '0;
      end else begin
         amp_ff <= amp_in;
      end
   end

   // Handshake: the input register moves on when the result register is free.
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_func_ff            <= req_func;
         in_tone_ff            <= req_tone_code;
         in_route_ff.speaker   <= req_speaker_on;
         in_route_ff.line      <= req_line_on;
         in_route_ff.handset   <= req_handset_on;
         in_route_ff.progress  <= req_progress_on;
         in_route_ff.open_loop <= req_open_loop;
      end
   end

   // Control decode and stored dialer state.
   dtmf_ctrl #(
      .PHASE_BITS (PHASE_BITS),
      .SAMPLE_HZ  (SAMPLE_HZ)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .write     (advance && (in_func_ff == FUNC_WRITE)),
      .tone_code (in_tone_ff),
      .route     (in_route_ff),
      .status    (status),
      .sound_on  (sound_on),
      .step_low  (step_low),
      .step_high (step_high)
   );

   assign osc_ctrl.tick     = advance && (in_func_ff == FUNC_TICK);
   assign osc_ctrl.sound_on = sound_on;

   // Row and column oscillators.
   dtmf_osc #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_INDEX_BITS (SINE_INDEX_BITS)
   ) u_osc_low (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (osc_ctrl),
      .step      (step_low),
      .amplitude (amp_ff),
      .tone      (tone_low)
   );

   dtmf_osc #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_INDEX_BITS (SINE_INDEX_BITS)
   ) u_osc_high (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (osc_ctrl),
      .step      (step_high),
      .amplitude (amp_ff),
      .tone      (tone_high)
   );

   // The sample is the sum of both tones on a sounding tick, else zero.
   assign rsp_sample_in = ((in_func_ff == FUNC_TICK) && sound_on) ?
                          tone_low + tone_high : 16'sd0;

   // Result register payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sample_ff <= rsp_sample_in;
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample         = rsp_sample_ff;
   assign rsp_tone_active    = rsp_status_ff.tone_active;
   assign rsp_tone_level     = rsp_status_ff.tone_level;
   assign rsp_low_freq_hz    = rsp_status_ff.low_freq_hz;
   assign rsp_high_freq_hz   = rsp_status_ff.high_freq_hz;
   assign rsp_route_speaker  = rsp_status_ff.route.speaker;
   assign rsp_route_line     = rsp_status_ff.route.line;
   assign rsp_route_handset  = rsp_status_ff.route.handset;
   assign rsp_route_progress = rsp_status_ff.route.progress;
   assign rsp_route_open     = rsp_status_ff.route.open_loop;
   assign rsp_digit_start    = rsp_status_ff.digit_start;

   // A digit start always comes with an active tone routed to the line.
   a_digit_to_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff.digit_start |->
         rsp_status_ff.tone_active && rsp_status_ff.route.line)
      else $error("digit start without an active line tone");

   // With no active tone the sample must be silent.
   a_silent_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_status_ff.tone_active |-> rsp_sample_ff == 16'sd0)
      else $error("nonzero sample while the tone is inactive");

   // The input register is full whenever the input side is stalled.
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && !advance)
      else $error("input stalled while the input register can move");

endmodule
